[rtl/grwh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grwh_pkg
// Shared types and codes for the grid ray wall hit block.
// ----------------------------------------------------------------------------
package grwh_pkg;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_CAST    = 2'd1;
    localparam logic [1:0] MODE_RESOLVE = 2'd2;

    localparam logic [1:0] CFG_MAP_WIDTH = 2'd0;
    localparam logic [1:0] CFG_MAP_CELLS = 2'd1;
    localparam logic [1:0] CFG_MAX_STEPS = 2'd2;

    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_SOUTH = 2'd1;
    localparam logic [1:0] SIDE_EAST  = 2'd2;
    localparam logic [1:0] SIDE_WEST  = 2'd3;

    localparam logic [11:0] QUARTER_TURN   = 12'd1024;
    localparam logic [11:0] HALF_TURN      = 12'd2048;
    localparam logic [11:0] THREE_QUARTERS = 12'd3072;

    // One classified job handed from the front to the back.
    typedef struct packed {
        logic        resolve;
        logic        map_write;
        logic        orient;
        logic [23:0] start_x;
        logic [23:0] start_y;
        logic [23:0] step_x;
        logic [23:0] step_y;
        logic [14:0] player_x;
        logic [14:0] player_y;
        logic [11:0] angle;
        logic [11:0] cell_index;
        logic        cell_wall;
    } t_job;

endpackage
`default_nettype wire

[rtl/grid_ray_wall_hit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_wall_hit_top
// Ray walk over a one-bit wall map with hit distance and nearest-side resolve.
// ----------------------------------------------------------------------------
// Map write, cast and resolve requests wait in order in a two-entry queue ahead
// of the walker; busy is high while that queue is full. The walker takes a
// queued request only while idle and never takes two in a row. A map write
// gives no result and is applied to the map when the walker takes it. A cast
// walks the ray one grid step at a time (tile, index multiply, map read,
// check) for up to max_steps steps. On a hit it then takes the absolute
// values, forms two squares and runs a 26-step bit-pair square root. A
// resolve request gives its strobe in the cycle after the walker takes it.
// Results appear for one cycle on o_valid and the receiver cannot stall them.
// The user must write configuration only while idle; the block itself does
// not enforce it.
module grid_ray_wall_hit_top #(
    parameter int MAP_CELLS_MAX = 4096,
    parameter int TILE_SHIFT    = 6
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         i_mode,
    input  wire                i_orient,
    input  wire  signed [23:0] i_start_x,
    input  wire  signed [23:0] i_start_y,
    input  wire  signed [23:0] i_step_x,
    input  wire  signed [23:0] i_step_y,
    input  wire  [14:0]        i_player_x,
    input  wire  [14:0]        i_player_y,
    input  wire  [11:0]        i_angle,
    input  wire  [11:0]        i_cell_index,
    input  wire                i_cell_wall,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [12:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [23:0] o_hit_x,
    output logic signed [23:0] o_hit_y,
    output logic [24:0]        o_distance,
    output logic [1:0]         o_side
);
    import grwh_pkg::*;

    logic [12:0] r_map_width, r_map_cells;
    logic [7:0]  r_max_steps;
    logic        take, deq, avail, full, idle;
    t_job        in_job, q_job;

    assign busy = full;
    assign take = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign in_job = '{resolve: (i_mode == MODE_RESOLVE),
                      map_write: (i_mode == MODE_WRITE), orient: i_orient,
                      start_x: i_start_x, start_y: i_start_y,
                      step_x: i_step_x, step_y: i_step_y,
                      player_x: i_player_x, player_y: i_player_y,
                      angle: i_angle, cell_index: i_cell_index,
                      cell_wall: i_cell_wall};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= 13'd64;
            r_map_cells <= 13'd4096;
            r_max_steps <= 8'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH: r_map_width <= i_cfg_data;
                CFG_MAP_CELLS: r_map_cells <= i_cfg_data;
                CFG_MAX_STEPS: r_max_steps <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    grwh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_mode(i_mode),
        .i_job(in_job), .i_deq(deq), .o_full(full), .o_avail(avail),
        .o_job(q_job)
    );

    grwh_back #(.MAP_CELLS_MAX(MAP_CELLS_MAX), .TILE_SHIFT(TILE_SHIFT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_map_width(r_map_width),
        .i_map_cells(r_map_cells), .i_max_steps(r_max_steps),
        .i_avail(avail), .i_job(q_job), .o_deq(deq), .o_idle(idle),
        .o_valid(o_valid), .o_hit(o_hit), .o_hit_x(o_hit_x), .o_hit_y(o_hit_y),
        .o_distance(o_distance), .o_side(o_side)
    );

`ifndef SYNTHESIS
    // A result is only produced with the walker returning to or staying idle.
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> idle) else $error("result while walker busy");
    // A miss carries no distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_distance == 25'd0)) else $error("miss dist");
    // The queue is never popped while empty.
    a_deq_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq |-> $past(avail)) else $error("pop of empty queue");
`endif
endmodule
`default_nettype wire

[rtl/grwh_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grwh_front
// Accepts requests and queues map write, cast and resolve jobs in order.
// ----------------------------------------------------------------------------
module grwh_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_take,
    input  wire  [1:0]        i_mode,
    input  grwh_pkg::t_job    i_job,
    input  wire               i_deq,
    output logic              o_full,
    output logic              o_avail,
    output grwh_pkg::t_job    o_job
);
    import grwh_pkg::*;

    // Two-entry queue.
    t_job       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       push;

    assign push    = i_take && (i_mode == MODE_WRITE || i_mode == MODE_CAST ||
                                i_mode == MODE_RESOLVE);
    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_deq) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_deq};
        end
    end
endmodule
`default_nettype wire

[rtl/grwh_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grwh_back
// Holds the wall map, walks cast rays, runs the square root and resolves.
// ----------------------------------------------------------------------------
module grwh_back #(
    parameter int MAP_CELLS_MAX = 4096,
    parameter int TILE_SHIFT    = 6
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [12:0]                      i_map_width,
    input  wire  [12:0]                      i_map_cells,
    input  wire  [7:0]                       i_max_steps,
    input  wire                              i_avail,
    input  grwh_pkg::t_job                   i_job,
    output logic                             o_deq,
    output logic                             o_idle,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic signed [23:0]               o_hit_x,
    output logic signed [23:0]               o_hit_y,
    output logic [24:0]                      o_distance,
    output logic [1:0]                       o_side
);
    import grwh_pkg::*;

    localparam int AW = $clog2(MAP_CELLS_MAX);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TILE = 4'd1;
    localparam logic [3:0] S_IDX  = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_ROOT = 4'd6;
    localparam logic [3:0] S_SQX  = 4'd7;
    localparam logic [3:0] S_SQY  = 4'd8;

    logic         r_map [MAP_CELLS_MAX];
    logic         r_rdat;
    logic [3:0]   r_st;
    t_job         r_job;
    logic [23:0]  r_x, r_y;
    logic [7:0]   r_cnt;
    logic signed [24:0] r_tx, r_ty;
    logic signed [38:0] r_mp;
    logic [25:0]  r_ax, r_ay;
    logic [51:0]  r_sq;
    logic [51:0]  r_rem;
    logic [51:0]  r_res;
    logic [51:0]  r_bit;
    logic [23:0]  r_hx_x, r_hx_y, r_vt_x, r_vt_y;
    logic [24:0]  r_hx_d, r_vt_d;

    function automatic logic signed [24:0] tile_of(input logic [23:0] q);
        logic signed [15:0] whole;
        logic [16:0] m;
        begin
            whole = q[23] ? -$signed(16'((~q + 24'd1) >> 8))
                          : $signed({1'b0, q[22:8]});
            if (whole < 0) begin
                m = 17'(-whole) + 17'((1 << TILE_SHIFT) - 1);
                tile_of = -$signed(25'(m >> TILE_SHIFT));
            end else begin
                tile_of = $signed(25'(whole >>> TILE_SHIFT));
            end
        end
    endfunction

    logic signed [25:0] dx, dy;
    logic [51:0] trial;
    logic mp_ok;
    logic wr_en;

    assign dx = $signed({r_x[23], r_x, 1'b0}) >>> 1;
    assign trial = r_res + r_bit;
    assign mp_ok = (r_mp > 0) && (r_mp < $signed({26'd0, i_map_cells}))
                   && (r_mp < MAP_CELLS_MAX);
    assign o_idle = (r_st == S_IDLE);
    assign dy = 26'(signed'(r_y));
    // Map writes take effect in queue order, when the walker picks them up.
    assign wr_en = i_rst_n && (r_st == S_IDLE) && i_avail && !o_deq && i_job.map_write;

    always_ff @(posedge i_clk) begin
        if (wr_en && (32'(i_job.cell_index) < MAP_CELLS_MAX)) begin
            r_map[AW'(i_job.cell_index)] <= i_job.cell_wall;
        end
        r_rdat <= r_map[AW'(r_mp)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
            o_deq   <= 1'b0;
            r_cnt   <= 8'd0;
            r_hx_x <= '0; r_hx_y <= '0; r_hx_d <= '0;
            r_vt_x <= '0; r_vt_y <= '0; r_vt_d <= '0;
        end else begin
            o_valid <= 1'b0;
            o_deq   <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_avail && !o_deq) begin
                        o_deq <= 1'b1;
                        r_job <= i_job;
                        r_x   <= i_job.start_x;
                        r_y   <= i_job.start_y;
                        r_cnt <= 8'd0;
                        if (i_job.resolve) begin
                            o_valid <= 1'b1;
                            o_hit   <= 1'b1;
                            if (r_vt_d < r_hx_d) begin
                                o_hit_x    <= r_vt_x;
                                o_hit_y    <= r_vt_y;
                                o_distance <= r_vt_d;
                                o_side <= (i_job.angle <= QUARTER_TURN ||
                                           i_job.angle > THREE_QUARTERS)
                                          ? SIDE_WEST : SIDE_EAST;
                            end else begin
                                o_hit_x    <= r_hx_x;
                                o_hit_y    <= r_hx_y;
                                o_distance <= r_hx_d;
                                o_side <= (i_job.angle < HALF_TURN)
                                          ? SIDE_SOUTH : SIDE_NORTH;
                            end
                        end else if (!i_job.map_write) begin
                            r_st <= S_TILE;
                        end
                    end
                end
                S_TILE: begin
                    if (r_cnt >= i_max_steps) begin
                        o_valid <= 1'b1;
                        o_hit <= 1'b0; o_hit_x <= '0; o_hit_y <= '0;
                        o_distance <= '0; o_side <= SIDE_NORTH;
                        r_st <= S_IDLE;
                    end else begin
                        r_tx <= tile_of(r_x);
                        r_ty <= tile_of(r_y);
                        r_st <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_mp <= 39'(r_ty * $signed({1'b0, i_map_width})) + 39'(r_tx);
                    r_st <= S_READ;
                end
                S_READ: r_st <= S_CHK;
                S_CHK: begin
                    if (mp_ok && r_rdat) begin
                        r_ax <= 26'(dx - $signed({3'd0, r_job.player_x, 8'd0}));
                        r_ay <= 26'(dy - $signed({3'd0, r_job.player_y, 8'd0}));
                        r_cnt <= i_max_steps;
                        r_st <= S_SQ;
                    end else begin
                        r_x <= r_x + r_job.step_x;
                        r_y <= r_y + r_job.step_y;
                        r_cnt <= r_cnt + 8'd1;
                        r_st <= S_TILE;
                    end
                end
                S_SQ: begin
                    r_ax <= r_ax[25] ? -r_ax : r_ax;
                    r_ay <= r_ay[25] ? -r_ay : r_ay;
                    r_st <= S_SQX;
                end
                S_SQX: begin
                    // Squares are formed one per cycle before the root.
                    r_sq <= r_ax * r_ax;
                    r_st <= S_SQY;
                end
                S_SQY: begin
                    r_rem <= r_sq + r_ay * r_ay;
                    r_res <= '0;
                    r_bit <= 52'd1 << 50;
                    r_st  <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_bit != '0) begin
                        if (r_rem >= trial) begin
                            r_rem <= r_rem - trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        o_valid <= 1'b1;
                        o_hit <= 1'b1; o_hit_x <= r_x; o_hit_y <= r_y;
                        o_distance <= r_res[24:0]; o_side <= SIDE_NORTH;
                        if (r_job.orient) begin
                            r_vt_x <= r_x; r_vt_y <= r_y; r_vt_d <= r_res[24:0];
                        end else begin
                            r_hx_x <= r_x; r_hx_y <= r_y; r_hx_d <= r_res[24:0];
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
